// ----- sv/abf_pkg.sv -----
// Shared constants, types and the reciprocal helper function of the alpha bleed filter.
`default_nettype none
package abf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int DIM_W      = 11;
    localparam int CNT_W      = 21;
    localparam int ADDR_W     = $clog2(2 * MAX_WIDTH + 3);
    localparam int TAP_W      = 4;
    localparam int SUM_W      = 11;
    localparam int NUM_W      = 4;
    localparam int RECIP_W    = 17;
    localparam int RECIP_SH   = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

    localparam logic [TAP_W-1:0] TAP_CENTER = 4'd4;
    localparam logic [TAP_W-1:0] TAP_LAST   = 4'd8;

    typedef struct packed {
        logic accept;
        logic start;
        logic issue;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic emit_due;
        logic out_busy;
        logic tap_last;
    } sts_t;

    // Rounded-up reciprocal scaled by 2^16; exact for sums below 2048.
    function automatic logic [RECIP_W-1:0] recip(input logic [NUM_W-1:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- sv/abf_ctrl.sv -----
// Controller state machine of the alpha bleed filter.
`default_nettype none
module abf_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire abf_pkg::sts_t sts,
    output abf_pkg::cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_READ  = 5'b00100,
        S_LAST  = 5'b01000,
        S_DIV   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.emit_due)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.issue = 1'b1;
                if (sts.tap_last)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // The result waits here until the output register is free.
                if (!sts.out_busy)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- sv/abf_datapath.sv -----
// Datapath of the alpha bleed filter: counters, pixel ring, window sums and output register.
`default_nettype none
module abf_datapath
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [abf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [abf_pkg::DIM_W-1:0]      cfg_data,
    input  wire logic                           req_type,
    input  wire logic [7:0]                     in_red,
    input  wire logic [7:0]                     in_green,
    input  wire logic [7:0]                     in_blue,
    input  wire logic [7:0]                     in_alpha,
    input  wire abf_pkg::cmd_t                  cmd,
    output abf_pkg::sts_t                       sts,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [7:0]                          out_red,
    output logic [7:0]                          out_green,
    output logic [7:0]                          out_blue,
    output logic [7:0]                          out_alpha,
    output logic                                frame_end
);

    logic [abf_pkg::DIM_W-1:0]   w_reg;
    logic [abf_pkg::DIM_W-1:0]   h_reg;
    logic [abf_pkg::CNT_W-1:0]   in_cnt_reg;
    logic [abf_pkg::CNT_W-1:0]   out_cnt_reg;
    logic [abf_pkg::DIM_W-1:0]   x_reg;
    logic [abf_pkg::DIM_W-1:0]   y_reg;
    logic                        eff_reg;
    logic [abf_pkg::TAP_W-1:0]   tap_reg;
    logic [abf_pkg::TAP_W-1:0]   rd_tap_reg;
    logic                        rd_ok_reg;
    logic                        rd_vld_reg;
    logic [31:0]                 rd_data_reg;
    logic [31:0]                 center_reg;
    logic [abf_pkg::SUM_W-1:0]   sr_reg;
    logic [abf_pkg::SUM_W-1:0]   sg_reg;
    logic [abf_pkg::SUM_W-1:0]   sb_reg;
    logic [abf_pkg::NUM_W-1:0]   n_reg;
    logic                        out_vld_reg;
    logic [7:0]                  ored_reg;
    logic [7:0]                  ogreen_reg;
    logic [7:0]                  oblue_reg;
    logic [7:0]                  oalpha_reg;
    logic                        ofe_reg;

    logic [31:0] mem [2**abf_pkg::ADDR_W];

    logic [abf_pkg::DIM_W-1:0]   eff_w;
    logic [abf_pkg::DIM_W-1:0]   eff_h;
    logic [abf_pkg::CNT_W-1:0]   total;
    logic                        in_full;
    logic                        do_write;
    logic [abf_pkg::CNT_W:0]     need;
    logic [abf_pkg::CNT_W-1:0]   idx;
    logic                        row_ok;
    logic                        col_ok;
    logic [abf_pkg::CNT_W-1:0]   out_inc;
    logic                        last_px;
    logic [27:0]                 qr;
    logic [27:0]                 qg;
    logic [27:0]                 qb;
    logic [abf_pkg::RECIP_W-1:0] rcp;
    logic                        keep_center;

    always_comb
    begin
        eff_w = w_reg;
        if (w_reg == '0)
        begin
            eff_w = abf_pkg::DIM_W'(1);
        end
        else if (w_reg > abf_pkg::DIM_W'(abf_pkg::MAX_WIDTH))
        begin
            eff_w = abf_pkg::DIM_W'(abf_pkg::MAX_WIDTH);
        end
        eff_h = h_reg;
        if (h_reg == '0)
        begin
            eff_h = abf_pkg::DIM_W'(1);
        end
        else if (h_reg > abf_pkg::DIM_W'(abf_pkg::MAX_HEIGHT))
        begin
            eff_h = abf_pkg::DIM_W'(abf_pkg::MAX_HEIGHT);
        end
    end

    assign total    = abf_pkg::CNT_W'(eff_w) * abf_pkg::CNT_W'(eff_h);
    assign in_full  = (in_cnt_reg == total);
    assign do_write = cmd.accept && !req_type && (in_cnt_reg < total);
    assign need     = {1'b0, out_cnt_reg} + (abf_pkg::CNT_W + 1)'(eff_w) + 22'd2;

    assign sts.emit_due = eff_reg && (out_cnt_reg < total)
                          && (in_full || ({1'b0, in_cnt_reg} >= need));
    assign sts.out_busy = out_vld_reg;
    assign sts.tap_last = (tap_reg == abf_pkg::TAP_LAST);

    // Neighbor position of the current tap: row offset from tap / 3, column from tap % 3.
    always_comb
    begin
        idx    = out_cnt_reg;
        row_ok = 1'b1;
        col_ok = 1'b1;
        case (tap_reg)
            4'd0, 4'd1, 4'd2:
            begin
                idx    = out_cnt_reg - abf_pkg::CNT_W'(eff_w);
                row_ok = (y_reg != '0);
            end
            4'd6, 4'd7, 4'd8:
            begin
                idx    = out_cnt_reg + abf_pkg::CNT_W'(eff_w);
                row_ok = ((y_reg + abf_pkg::DIM_W'(1)) < eff_h);
            end
            default:
            begin
                idx    = out_cnt_reg;
                row_ok = 1'b1;
            end
        endcase
        case (tap_reg)
            4'd0, 4'd3, 4'd6:
            begin
                idx    = idx - abf_pkg::CNT_W'(1);
                col_ok = (x_reg != '0);
            end
            4'd2, 4'd5, 4'd8:
            begin
                idx    = idx + abf_pkg::CNT_W'(1);
                col_ok = ((x_reg + abf_pkg::DIM_W'(1)) < eff_w);
            end
            default:
            begin
                col_ok = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[in_cnt_reg[abf_pkg::ADDR_W-1:0]] <= {in_alpha, in_blue, in_green, in_red};
        end
        if (cmd.issue)
        begin
            rd_data_reg <= mem[idx[abf_pkg::ADDR_W-1:0]];
        end
    end

    assign rcp         = abf_pkg::recip(n_reg);
    assign qr          = 28'(sr_reg) * 28'(rcp);
    assign qg          = 28'(sg_reg) * 28'(rcp);
    assign qb          = 28'(sb_reg) * 28'(rcp);
    assign keep_center = (center_reg[31:24] != 8'd0) || (n_reg == '0);
    assign out_inc     = out_cnt_reg + abf_pkg::CNT_W'(1);
    assign last_px     = (out_inc == total);

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            rd_tap_reg <= tap_reg;
            rd_ok_reg  <= row_ok && col_ok && (tap_reg != abf_pkg::TAP_CENTER);
        end
        if (cmd.start)
        begin
            sr_reg <= '0;
            sg_reg <= '0;
            sb_reg <= '0;
            n_reg  <= '0;
        end
        else if (rd_vld_reg)
        begin
            if (rd_tap_reg == abf_pkg::TAP_CENTER)
            begin
                center_reg <= rd_data_reg;
            end
            else if (rd_ok_reg && (rd_data_reg[31:24] != 8'd0))
            begin
                sr_reg <= sr_reg + abf_pkg::SUM_W'(rd_data_reg[7:0]);
                sg_reg <= sg_reg + abf_pkg::SUM_W'(rd_data_reg[15:8]);
                sb_reg <= sb_reg + abf_pkg::SUM_W'(rd_data_reg[23:16]);
                n_reg  <= n_reg + abf_pkg::NUM_W'(1);
            end
        end
        if (cmd.load)
        begin
            if (keep_center)
            begin
                ored_reg   <= center_reg[7:0];
                ogreen_reg <= center_reg[15:8];
                oblue_reg  <= center_reg[23:16];
                oalpha_reg <= center_reg[31:24];
            end
            else
            begin
                ored_reg   <= qr[abf_pkg::RECIP_SH+7:abf_pkg::RECIP_SH];
                ogreen_reg <= qg[abf_pkg::RECIP_SH+7:abf_pkg::RECIP_SH];
                oblue_reg  <= qb[abf_pkg::RECIP_SH+7:abf_pkg::RECIP_SH];
                oalpha_reg <= 8'd0;
            end
            ofe_reg <= last_px;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg       <= abf_pkg::DIM_W'(1024);
            h_reg       <= abf_pkg::DIM_W'(1024);
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
            x_reg       <= '0;
            y_reg       <= '0;
            eff_reg     <= 1'b0;
            tap_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.issue;
            if (cmd.accept)
            begin
                eff_reg <= do_write || in_full;
            end
            if (do_write)
            begin
                in_cnt_reg <= in_cnt_reg + abf_pkg::CNT_W'(1);
            end
            if (cmd.start)
            begin
                tap_reg <= '0;
            end
            else if (cmd.issue && (tap_reg != abf_pkg::TAP_LAST))
            begin
                tap_reg <= tap_reg + abf_pkg::TAP_W'(1);
            end
            if (out_vld_reg && out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
            if (cmd.load)
            begin
                out_vld_reg <= 1'b1;
                if (last_px)
                begin
                    out_cnt_reg <= '0;
                    in_cnt_reg  <= '0;
                    x_reg       <= '0;
                    y_reg       <= '0;
                end
                else
                begin
                    out_cnt_reg <= out_inc;
                    if ((x_reg + abf_pkg::DIM_W'(1)) == eff_w)
                    begin
                        x_reg <= '0;
                        y_reg <= y_reg + abf_pkg::DIM_W'(1);
                    end
                    else
                    begin
                        x_reg <= x_reg + abf_pkg::DIM_W'(1);
                    end
                end
            end
            // Any register write restarts the frame.
            if (cfg_we && ((cfg_index == abf_pkg::REG_WIDTH)
                           || (cfg_index == abf_pkg::REG_HEIGHT)))
            begin
                if (cfg_index == abf_pkg::REG_WIDTH)
                begin
                    w_reg <= cfg_data;
                end
                else
                begin
                    h_reg <= cfg_data;
                end
                in_cnt_reg  <= '0;
                out_cnt_reg <= '0;
                x_reg       <= '0;
                y_reg       <= '0;
            end
        end
    end

    assign out_valid = out_vld_reg;
    assign out_red   = ored_reg;
    assign out_green = ogreen_reg;
    assign out_blue  = oblue_reg;
    assign out_alpha = oalpha_reg;
    assign frame_end = ofe_reg;

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !out_vld_reg)
        else $error("result loaded over a pending item");
    a_out_behind_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_cnt_reg <= in_cnt_reg)
        else $error("output count ran ahead of input count");
    a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
        tap_reg <= abf_pkg::TAP_LAST)
        else $error("window tap out of range");
    a_issue_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (cmd.issue && tap_reg == '0))
        else $error("window read did not begin at the first tap");
`endif

endmodule
`default_nettype wire

// ----- sv/alpha_bleed_3x3_filter_unit.sv -----
// Top level of the alpha bleed 3x3 filter: controller and datapath.
// Usage:
// Pixels enter in raster order on the valid/ready input channel; req_type 1
// marks a flush item that drains one pending pixel once the frame is complete.
// The pixel with raster index k leaves with the item that carries pixel
// k+width+1; the last width+1 pixels leave one per flush item.
// Image size is written through cfg_we/cfg_index/cfg_data while idle; each
// write restarts the frame.
// One item at a time: an item with no result passes S_IDLE and S_CHECK; one
// with a result goes on to S_READ, S_LAST and S_DIV to the output register,
// with nine sequential reads of the 3x3 window through the single pixel ring port.
// The output register holds a result until out_ready; the next item is taken
// meanwhile, and a further result waits in the controller until it is free.
// Reset clears counters and control and sets the size to 1024 by 1024; the
// pixel ring is not cleared and needs no clearing pass.
`default_nettype none
module alpha_bleed_3x3_filter_unit
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [abf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [abf_pkg::DIM_W-1:0]     cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          req_type,
    input  wire logic [7:0]                    in_red,
    input  wire logic [7:0]                    in_green,
    input  wire logic [7:0]                    in_blue,
    input  wire logic [7:0]                    in_alpha,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [7:0]                         out_red,
    output logic [7:0]                         out_green,
    output logic [7:0]                         out_blue,
    output logic [7:0]                         out_alpha,
    output logic                               frame_end
);

    abf_pkg::cmd_t cmd;
    abf_pkg::sts_t sts;

    abf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    abf_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_type  (req_type),
        .in_red    (in_red),
        .in_green  (in_green),
        .in_blue   (in_blue),
        .in_alpha  (in_alpha),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .out_alpha (out_alpha),
        .frame_end (frame_end)
    );

endmodule
`default_nettype wire
